// ===== hdl/lru_key_value_cache_macros.svh =====
// Assertion macros shared by the LRU key-value cache modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LKV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int KEY_BITS        = 64;
    localparam int VALUE_PORT_BITS = 64;

    // Request codes on the operation field
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // register the accepted request beat
        logic compare;  // register key match, free slot and victim vectors
        logic update;   // apply the request to the store
        logic load;     // move the finished result into the output register
    } t_lkv_cmd;

endpackage

// ===== hdl/lkv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data between reads
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lkv_ctrl.sv =====
// Sequencer for the LRU key-value cache: handshakes and datapath commands.
// Depends on lkv_pkg and lru_key_value_cache_macros.svh.
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lkv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lkv_pkg::t_lkv_cmd o_cmd
);

    import lkv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_accept;
    logic       out_free;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    // result register can take a new beat this cycle
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.compare = 1'b0;
        o_cmd.update  = 1'b0;
        o_cmd.load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_ACT;
            end
            ST_ACT: begin
                o_cmd.update = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                // wait here until the previous result has left
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `LKV_ASSERT_NOW(a_no_overwrite, o_cmd.load, !r_out_valid || !i_out_stall, "result overwritten while stalled")
    `LKV_ASSERT_NEXT(a_accept_to_cmp, in_accept, r_state == ST_CMP, "accepted beat did not start compare")

endmodule

// ===== hdl/lkv_dpath.sv =====
// Datapath of the LRU key-value cache: key CAM, age ranks, value RAM, result register.
// Depends on lkv_pkg, lkv_ram and lru_key_value_cache_macros.svh.
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lkv_dpath #(
    parameter int ENTRIES    = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  lkv_pkg::t_lkv_cmd                          i_cmd,
    input  logic                                       i_operation,
    input  logic signed [lkv_pkg::KEY_BITS-1:0]        i_lookup_key,
    input  logic [lkv_pkg::VALUE_PORT_BITS-1:0]        i_write_value,
    output logic                                       o_hit,
    output logic [lkv_pkg::VALUE_PORT_BITS-1:0]        o_read_value,
    output logic                                       o_evicted
);

    import lkv_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);

    // request beat
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;

    // store
    logic [KEY_BITS-1:0] r_slot_key [ENTRIES];
    logic [IDX_W-1:0]    r_rank     [ENTRIES];
    logic [IDX_W-1:0]    n_rank     [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  n_valid;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;

    // compare results
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] n_match;
    logic [ENTRIES-1:0] r_free;
    logic [ENTRIES-1:0] n_free;
    logic [ENTRIES-1:0] r_victim;
    logic [ENTRIES-1:0] n_victim;
    logic               r_full;

    // update
    logic               hit;
    logic               put;
    logic [IDX_W-1:0]   old_rank;
    logic [ENTRIES-1:0] target;
    logic [ENTRIES-1:0] sel_oh;
    logic [IDX_W-1:0]   sel_idx;
    logic               ram_we;
    logic               ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    // staged and output result
    logic                       r_res_hit;
    logic                       r_res_evict;
    logic                       r_res_read;
    logic                       r_out_hit;
    logic                       r_out_evict;
    logic [VALUE_PORT_BITS-1:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i]  = r_valid[i] && (r_slot_key[i] == r_key);
            // when full the ranks are a permutation, so the oldest holds the top rank
            n_victim[i] = r_valid[i] && (r_rank[i] == LAST_RANK);
        end
        // lowest-numbered empty slot
        n_free = (~r_valid) & (r_valid + ENTRIES'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_match  <= n_match;
            r_free   <= n_free;
            r_victim <= n_victim;
            r_full   <= (r_fill == FULL_CNT);
        end
    end

    assign hit    = |r_match;
    assign put    = (r_op == OP_PUT);
    assign target = r_full ? r_victim : r_free;
    assign sel_oh = hit ? r_match : target;

    always_comb begin
        old_rank = '0;
        sel_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                old_rank = old_rank | r_rank[i];
            end
            if (sel_oh[i]) begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_fill  = r_fill;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (hit) begin
                // touch: younger entries age by one
                if (r_match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < old_rank)) begin
                    n_rank[i] = IDX_W'(r_rank[i] + 1'b1);
                end
            end else if (put) begin
                // insert: every other valid entry ages by one
                if (target[i]) begin
                    n_rank[i]  = '0;
                    n_valid[i] = 1'b1;
                end else if (r_valid[i]) begin
                    n_rank[i] = IDX_W'(r_rank[i] + 1'b1);
                end
            end
        end
        if (!hit && put && !r_full) begin
            n_fill = CNT_W'(r_fill + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            r_valid <= n_valid;
            r_fill  <= n_fill;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.update && !hit && put && target[i]) begin
                r_slot_key[i] <= r_key;
            end
        end
    end

    assign ram_we = i_cmd.update && put;
    assign ram_re = i_cmd.update && hit && !put;

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (sel_idx),
        .i_wr_data (r_wval),
        .i_rd_en   (ram_re),
        .i_rd_addr (sel_idx),
        .o_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_hit   <= hit;
            r_res_evict <= put && !hit && r_full;
            r_res_read  <= hit && !put;
        end
        if (i_cmd.load) begin
            r_out_hit   <= r_res_hit;
            r_out_evict <= r_res_evict;
            r_out_value <= r_res_read ? VALUE_PORT_BITS'(ram_rdata) : '0;
        end
    end

    assign o_hit        = r_out_hit;
    assign o_evicted    = r_out_evict;
    assign o_read_value = r_out_value;

    `LKV_ASSERT_NOW(a_fill_matches_valid, 1'b1, $countones(r_valid) == r_fill, "fill count disagrees with valid slots")
    `LKV_ASSERT_NOW(a_key_unique, i_cmd.update, $onehot0(r_match), "key present in more than one slot")

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkv_pkg, lkv_ctrl, lkv_dpath and lkv_ram.
`timescale 1ns / 1ps

// Fully associative key-value store of ENTRIES slots with least-recently-used
// replacement. A request beat (operation 0 = get, 1 = put) returns exactly one
// result beat: hit, read_value (get hits only, else zero) and evicted (put
// misses on a full store). Keys live in flip-flops and are compared in
// parallel; values live in a RAM with registered read. A request walks four
// controller steps: accept, key compare, store update with the value read, and
// result load. The compare vectors are registered before the update and the
// value RAM read is registered, so the result register loads in the load step
// once the previous result has left, and is offered from then on. The input
// takes the next request on the edge after that load and holds off new requests
// until then. A stalled result does not block the next request: that request
// runs up to its load step and waits there, and the input stalls until it has
// been loaded. No clearing pass is needed after reset.
module lru_key_value_cache #(
    parameter int ENTRIES    = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic signed [lkv_pkg::KEY_BITS-1:0]  i_lookup_key,
    input  logic [lkv_pkg::VALUE_PORT_BITS-1:0]  i_write_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_hit,
    output logic [lkv_pkg::VALUE_PORT_BITS-1:0]  o_read_value,
    output logic                                 o_evicted
);

    import lkv_pkg::*;

    t_lkv_cmd cmd;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lkv_dpath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

endmodule

// ===== verif/lru_key_value_cache_tb.sv =====
// Self-checking testbench for lru_key_value_cache: get/put beats with random gaps and stalls,
// each result beat checked against a shadow LRU store. Depends on lkv_pkg and the cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int ENTRIES    = 8;
    localparam int VALUE_BITS = 64;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] KEY_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX    = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_value;
        logic        evicted;
    } t_lookup_reply;

    class t_reply_board;
        logic [63:0]   slot_key[ENTRIES];
        logic [63:0]   slot_value[ENTRIES];
        bit            slot_valid[ENTRIES];
        int            slot_rank[ENTRIES];
        int            fill;
        t_lookup_reply pending[$];
        int            errors;

        function new();
            foreach (slot_valid[i]) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            fill   = 0;
            errors = 0;
        endfunction

        // Make idx the most recent; live slots younger than it age by one.
        function void promote(int idx);
            int old;
            old = slot_rank[idx];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && i != idx && slot_rank[i] < old)
                    slot_rank[i]++;
            slot_rank[idx] = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void note_request(logic op, logic [63:0] key, logic [63:0] wval);
            t_lookup_reply want;
            int            idx;
            int            target;
            int            worst;
            want   = '0;
            idx    = -1;
            target = -1;
            worst  = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (idx < 0 && slot_valid[i] && slot_key[i] == key)
                    idx = i;
            if (op == OP_GET) begin
                if (idx >= 0) begin
                    want.hit        = 1'b1;
                    want.read_value = slot_value[idx] & VALUE_MASK;
                    promote(idx);
                end
            end else if (idx >= 0) begin
                want.hit        = 1'b1;
                slot_value[idx] = wval & VALUE_MASK;
                promote(idx);
            end else begin
                if (fill >= ENTRIES) begin
                    // evict the oldest live slot; the lowest index wins a tie
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i] && (target < 0 || slot_rank[i] > worst)) begin
                            target = i;
                            worst  = slot_rank[i];
                        end
                    if (target >= 0) begin
                        slot_valid[target] = 1'b0;
                        fill--;
                        want.evicted = 1'b1;
                    end
                end
                if (target < 0)
                    for (int i = 0; i < ENTRIES; i++)
                        if (target < 0 && !slot_valid[i])
                            target = i;
                if (target >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i])
                            slot_rank[i]++;
                    slot_key[target]   = key;
                    slot_value[target] = wval & VALUE_MASK;
                    slot_valid[target] = 1'b1;
                    slot_rank[target]  = 0;
                    fill++;
                end
            end
            pending.push_back(want);
        endfunction

        function void check_response(logic hit, logic [63:0] value, logic evicted);
            t_lookup_reply got;
            t_lookup_reply want;
            got.hit        = hit;
            got.read_value = value;
            got.evicted    = evicted;
            if (pending.size() == 0) begin
                flag($sformatf("result beat with nothing outstanding: hit=%0b value=%h evicted=%0b",
                               hit, value, evicted));
            end else begin
                want = pending.pop_front();
                if (got !== want)
                    flag($sformatf({"result mismatch: expected hit=%0b value=%h evicted=%0b, ",
                                    "got hit=%0b value=%h evicted=%0b"},
                                   want.hit, want.read_value, want.evicted,
                                   got.hit, got.read_value, got.evicted));
            end
        endfunction

        function void close_out();
            if (pending.size() != 0)
                flag($sformatf("%0d result beats never arrived", pending.size()));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic signed [KEY_BITS-1:0] i_lookup_key;
    logic [VALUE_PORT_BITS-1:0] i_write_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_hit;
    logic [VALUE_PORT_BITS-1:0] o_read_value;
    logic        o_evicted;

    t_reply_board board = new();

    logic [63:0] key_pool[32];
    int          pool_size;
    bit          quiet;

    lru_key_value_cache #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int idle_length();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Keys come mostly from a small pool so hits and evictions are common.
    function automatic logic [63:0] pick_key();
        int r;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, pool_size - 1)];
        if (r < 4)
            return random_word();
        if (r < 9)
            k[$urandom_range(0, 63)] = ~k[$urandom_range(0, 63)];
        return k;
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return random_word();
    endfunction

    task automatic send_request(input logic op, input logic [63:0] key, input logic [63:0] wval);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_operation   = op;
        i_lookup_key  = key;
        i_write_value = wval;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(op, key, wval);
        @(negedge i_clk);
    endtask

    // Hold off new beats until every outstanding result has come back.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_response(o_hit, o_read_value, o_evicted);

    initial begin : out_stall_gen
        int stall_len;
        i_out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            stall_len = idle_length();
            if (stall_len > 0) begin
                i_out_stall = 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin : stimulus
        int sizes[6];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_GET;
        i_lookup_key  = '0;
        i_write_value = '0;
        quiet         = 1'b0;
        pool_size     = 12;
        sizes         = '{5, 9, 12, 20, 8, 30};
        key_pool[0]   = KEY_MIN;
        key_pool[1]   = KEY_MAX;
        key_pool[2]   = '0;
        key_pool[3]   = '1;
        for (int i = 4; i < 32; i++)
            key_pool[i] = (i < 10) ? 64'(i) : random_word();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty store, fill to capacity, hits of both kinds, eviction, near-miss key.
        send_request(OP_GET, '0, random_word());
        send_request(OP_PUT, KEY_MIN, '1);
        send_request(OP_PUT, KEY_MAX, '0);
        send_request(OP_PUT, '0, 64'h5555_5555_5555_5555);
        send_request(OP_PUT, '1, 64'haaaa_aaaa_aaaa_aaaa);
        for (int i = 1; i <= 4; i++)
            send_request(OP_PUT, 64'(i), random_word());
        send_request(OP_GET, KEY_MIN, '1);
        send_request(OP_PUT, KEY_MAX, 64'h0123_4567_89ab_cdef);
        send_request(OP_GET, '1, random_word());
        send_request(OP_PUT, 64'd5, random_word());
        send_request(OP_GET, '0, random_word());
        send_request(OP_GET, 64'd5, '0);
        send_request(OP_PUT, 64'd5, '1);
        send_request(OP_GET, KEY_MIN | 64'd1, random_word());
        send_request(OP_GET, KEY_MAX, random_word());
        send_request(OP_PUT, 64'd6, '0);
        send_request(OP_GET, 64'd5, random_word());
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            pool_size = sizes[phase];
            quiet     = (phase == 2);
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(0, 49) == 0)
                    key_pool[$urandom_range(4, 31)] = random_word();
                send_request(($urandom_range(0, 1) != 0) ? OP_PUT : OP_GET,
                             pick_key(), pick_value());
            end
            if (phase == 0 || phase == 3)
                wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        board.close_out();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
